FILE: src/utf8_subset_to_cp437_macros.svh
// assertion macros shared by the transcoder checker
// needs clk_i and rst_ni visible at the place of use
`ifndef UTF8_SUBSET_TO_CP437_MACROS_SVH
`define UTF8_SUBSET_TO_CP437_MACROS_SVH

// same-cycle implication, disabled while in reset
`define U8CP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("transcoder assertion failed");

// next-cycle implication, disabled while in reset
`define U8CP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("transcoder assertion failed");

`endif

FILE: src/u8cp_pkg.sv
// types, lead byte constants and mapping tables of the utf-8 to cp437 transcoder
// no dependencies
package u8cp_pkg;

  // decoder phase: idle, or one code per partial sequence
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_C2    = 3'd1,
    PH_C3    = 3'd2,
    PH_E2    = 3'd3,
    PH_E294  = 3'd4,
    PH_E295  = 3'd5,
    PH_E296  = 3'd6
  } u8cp_phase_e;

  localparam logic [7:0] BYTE_NUL  = 8'h00;
  localparam logic [7:0] LEAD_C2   = 8'hC2;
  localparam logic [7:0] LEAD_C3   = 8'hC3;
  localparam logic [7:0] LEAD_E2   = 8'hE2;
  localparam logic [7:0] MID_94    = 8'h94;
  localparam logic [7:0] MID_95    = 8'h95;
  localparam logic [7:0] MID_96    = 8'h96;

  // result of one decode step
  typedef struct packed {
    logic        emit;
    logic [7:0]  data;
    u8cp_phase_e next_phase;
  } u8cp_dec_t;

  // table lookup result
  typedef struct packed {
    logic       hit;
    logic [7:0] data;
  } u8cp_hit_t;

  // continuation after c2
  function automatic u8cp_hit_t map_c2(input logic [7:0] b);
    u8cp_hit_t r;
    r.hit = 1'b1;
    case (b)
      8'hA1:   r.data = 8'd173;
      8'hBF:   r.data = 8'd168;
      8'hB0:   r.data = 8'd248;
      8'hAC:   r.data = 8'd170;
      8'hBD:   r.data = 8'd250;
      default: begin
        r.hit  = 1'b0;
        r.data = 8'd0;
      end
    endcase
    return r;
  endfunction

  // continuation after c3
  function automatic u8cp_hit_t map_c3(input logic [7:0] b);
    u8cp_hit_t r;
    r.hit = 1'b1;
    case (b)
      8'hB1:   r.data = 8'd164;
      8'h91:   r.data = 8'd165;
      8'hA1:   r.data = 8'd160;
      8'hA9:   r.data = 8'd130;
      8'hAD:   r.data = 8'd161;
      8'hB3:   r.data = 8'd162;
      8'hBA:   r.data = 8'd163;
      8'h81:   r.data = 8'd181;
      8'h89:   r.data = 8'd144;
      8'h8D:   r.data = 8'd214;
      8'h93:   r.data = 8'd224;
      8'h9A:   r.data = 8'd233;
      default: begin
        r.hit  = 1'b0;
        r.data = 8'd0;
      end
    endcase
    return r;
  endfunction

  // box drawing, single lines
  function automatic u8cp_hit_t map_e294(input logic [7:0] b);
    u8cp_hit_t r;
    r.hit = 1'b1;
    case (b)
      8'h82:   r.data = 8'd179;
      8'h94:   r.data = 8'd192;
      8'h8C:   r.data = 8'd218;
      8'h80:   r.data = 8'd196;
      8'h90:   r.data = 8'd191;
      8'h98:   r.data = 8'd217;
      default: begin
        r.hit  = 1'b0;
        r.data = 8'd0;
      end
    endcase
    return r;
  endfunction

  // box drawing, double lines
  function automatic u8cp_hit_t map_e295(input logic [7:0] b);
    u8cp_hit_t r;
    r.hit = 1'b1;
    case (b)
      8'h94:   r.data = 8'd201;
      8'h90:   r.data = 8'd205;
      8'h91:   r.data = 8'd186;
      8'h97:   r.data = 8'd187;
      8'h9A:   r.data = 8'd200;
      8'h9D:   r.data = 8'd188;
      default: begin
        r.hit  = 1'b0;
        r.data = 8'd0;
      end
    endcase
    return r;
  endfunction

  // blocks and shades
  function automatic u8cp_hit_t map_e296(input logic [7:0] b);
    u8cp_hit_t r;
    r.hit = 1'b1;
    case (b)
      8'h88:   r.data = 8'd219;
      8'h92:   r.data = 8'd177;
      8'h91:   r.data = 8'd176;
      8'h93:   r.data = 8'd178;
      8'h84:   r.data = 8'd220;
      8'h80:   r.data = 8'd223;
      8'h8C:   r.data = 8'd219;
      8'h90:   r.data = 8'd219;
      8'hA0:   r.data = 8'd254;
      default: begin
        r.hit  = 1'b0;
        r.data = 8'd0;
      end
    endcase
    return r;
  endfunction

endpackage

FILE: src/u8cp_ifs.sv
// valid/ready channel interfaces for the transcoder's byte streams
// no dependencies
interface u8cp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8cp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface

FILE: src/u8cp_decode.sv
// one decode step: current phase and byte in, result and next phase out
// depends on u8cp_pkg
module u8cp_decode
  import u8cp_pkg::*;
(
  input  u8cp_phase_e phase_i,
  input  logic [7:0]  byte_i,
  output u8cp_dec_t   dec_o
);

  u8cp_hit_t hit;

  // table selected by the phase
  always_comb begin
    case (phase_i)
      PH_C2:   hit = map_c2(byte_i);
      PH_C3:   hit = map_c3(byte_i);
      PH_E294: hit = map_e294(byte_i);
      PH_E295: hit = map_e295(byte_i);
      PH_E296: hit = map_e296(byte_i);
      default: hit = '{hit: 1'b1, data: byte_i};
    endcase
  end

  // result and phase update
  always_comb begin
    dec_o.emit       = 1'b0;
    dec_o.data       = hit.data;
    dec_o.next_phase = PH_IDLE;
    if (byte_i == BYTE_NUL) begin
      // terminator abandons any partial sequence
      dec_o.emit = 1'b1;
      dec_o.data = BYTE_NUL;
    end else begin
      case (phase_i)
        PH_E2: begin
          case (byte_i)
            MID_94:  dec_o.next_phase = PH_E294;
            MID_95:  dec_o.next_phase = PH_E295;
            MID_96:  dec_o.next_phase = PH_E296;
            default: dec_o.next_phase = PH_IDLE;
          endcase
        end
        PH_C2, PH_C3, PH_E294, PH_E295, PH_E296: begin
          dec_o.emit = hit.hit;
        end
        default: begin
          // idle: lead bytes open a sequence, anything else passes through
          case (byte_i)
            LEAD_C2: dec_o.next_phase = PH_C2;
            LEAD_C3: dec_o.next_phase = PH_C3;
            LEAD_E2: dec_o.next_phase = PH_E2;
            default: dec_o.emit = 1'b1;
          endcase
        end
      endcase
    end
  end

endmodule

FILE: src/utf8_subset_to_cp437.sv
// Byte-stream transcoder from a subset of UTF-8 to code page 437.
// Input channel in_i carries one raw byte per item; output channel out_o
// carries zero or one cp437 byte per input item. C2 xx and C3 xx pairs and
// E2 94/95/96 xx triples that appear in the mapping tables become one byte;
// unmatched sequences are swallowed; other bytes pass through. A zero byte
// ends the string, clears any partial sequence and is passed on.
// An accepted item lands in the input register and is decoded into the
// result register, and offered from there, once the result register is
// empty or being read. Throughput: one item per cycle while the receiver
// takes results, set by the single decode step between the input
// register and the result register, which also updates the phase register.
// Reset clears both valid flags and returns the phase to idle.
// When the receiver stalls, the result register holds its byte; the input
// register still drains items that produce no result, and in_i.ready drops
// only once both the result register and the input register are occupied.
// Depends on u8cp_pkg, u8cp_ifs and u8cp_decode.
module utf8_subset_to_cp437
  import u8cp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  u8cp_in_if.sink     in_i,
  u8cp_out_if.source  out_o
);

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  u8cp_phase_e phase_q, phase_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q;
  u8cp_dec_t   dec;
  logic        out_free;
  logic        advance;
  logic        in_ready;

  u8cp_decode u_decode (
    .phase_i (phase_q),
    .byte_i  (in_byte_q),
    .dec_o   (dec)
  );

  // handshake control
  assign out_free = !out_valid_q || out_o.ready;
  assign advance  = in_valid_q && (!dec.emit || out_free);
  assign in_ready = !in_valid_q || advance;

  always_comb begin
    phase_d     = phase_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (advance) begin
      phase_d = dec.next_phase;
      if (dec.emit) begin
        out_valid_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      phase_q     <= PH_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_i.valid;
      end
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      in_byte_q <= in_i.in_byte;
    end
    if (advance && dec.emit) begin
      out_byte_q <= dec.data;
    end
  end

  assign in_i.ready     = in_ready;
  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;

endmodule

FILE: src/u8cp_checker.sv
// port-level assertions for the transcoder, bound to the top level
// depends on utf8_subset_to_cp437_macros.svh and utf8_subset_to_cp437
`include "utf8_subset_to_cp437_macros.svh"

module u8cp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i
);

  // a stalled item stays offered
  `U8CP_ASSERT_NEXT(out_valid_hold, out_valid_i && !out_ready_i, out_valid_i)

  // a stalled item keeps its byte
  `U8CP_ASSERT_NEXT(out_byte_hold, out_valid_i && !out_ready_i, $stable(out_byte_i))

  // lead bytes are never emitted on their own
  `U8CP_ASSERT_IMPL(no_lead_out, out_valid_i,
    out_byte_i != 8'hC2 && out_byte_i != 8'hC3 && out_byte_i != 8'hE2)

  // an empty result register never blocks the input
  `U8CP_ASSERT_IMPL(ready_when_empty, !out_valid_i, in_ready_i)

endmodule

bind utf8_subset_to_cp437 u8cp_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte)
);
